// ===== hw/rtl/gpt_pkg.sv =====
`timescale 1ns / 1ps
package gpt_pkg;

   localparam int unsigned CountWidth = 11;

   localparam logic [1:0] OP_OPEN  = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] row;
      logic [5:0] column;
   } req_type;

   typedef struct packed {
      logic        bad_index;
      logic        site_open;
      logic        site_full;
      logic        percolates;
      logic [10:0] open_sites;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WIPE,
      ST_OCHK,
      ST_OCHK_W,
      ST_NSEL,
      ST_NRD,
      ST_NRD_W,
      ST_FA,
      ST_FA_W,
      ST_FB,
      ST_FB_W,
      ST_SZ,
      ST_SZ_W,
      ST_LINK,
      ST_QRD,
      ST_QRD_W,
      ST_QF0,
      ST_QF0_W,
      ST_QF1,
      ST_QF1_W,
      ST_PT,
      ST_PT_W,
      ST_PB,
      ST_PB_W,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/grid_percolation_tracker_core.sv =====
`timescale 1ns / 1ps
// a query walks four roots: top, site, top again, bottom; an open of a closed site checks
// each site neighbour for its open state, walks both roots per join attempt and writes
// a link when they differ, then does what a query does; a bad address walks top and bottom.
// clear responds, then sweeps all MAX_SIDE^2 + 2 nodes, as after a csr write.
// one transaction at a time; the next is taken the cycle after a non-clear rsp_valid unless a sweep is pending.
// synchronous active high reset starts the clearing sweep; no stall on rsp.
module grid_percolation_tracker_core #(
   parameter int unsigned MAX_SIDE = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  gpt_pkg::req_type    req_data,
   output logic                rsp_valid,
   output gpt_pkg::rsp_type    rsp_data,
   input  logic                csr_wr_en,
   input  logic [5:0]          csr_wr_data
);

   localparam int unsigned Sites = MAX_SIDE * MAX_SIDE;
   localparam int unsigned Nodes = Sites + 2;
   localparam int unsigned NW    = $clog2(Nodes);
   localparam int unsigned SW    = (Sites > 1) ? $clog2(Sites) : 1;
   localparam int unsigned CW    = gpt_pkg::CountWidth;

   gpt_pkg::state_type state_ff, state_in;
   logic [5:0]     side_reg_ff, side_reg_in;
   logic [6:0]     n_ff, n_in;
   logic [NW-1:0]  wipe_ff, wipe_in;
   logic [1:0]     op_ff, op_in;
   logic [5:0]     r_ff, r_in, c_ff, c_in;
   logic [NW-1:0]  node_ff, node_in;
   logic [NW-1:0]  nb_ff, nb_in;
   logic [2:0]     nidx_ff, nidx_in;
   logic [NW-1:0]  cur_ff, cur_in;
   logic [NW-1:0]  ra_ff, ra_in;
   logic [NW-1:0]  rb_ff, rb_in;
   logic [NW-1:0]  sa_ff, sa_in;
   logic [CW-1:0]  total_ff, total_in;
   logic           bad_ff, bad_in, sopen_ff, sopen_in, sfull_ff, sfull_in;
   logic           perc_ff, perc_in;
   logic           wipe_pend_ff, wipe_pend_in;

   logic           o_we, o_wd, o_rd;
   logic [SW-1:0]  o_wa, o_ra;
   logic           p_we;
   logic [NW-1:0]  p_wa, p_wd, p_ra, p_rd;
   logic           s_we;
   logic [NW-1:0]  s_wa, s_ra;
   logic [NW-1:0]  s_wd, s_rd;

   gpt_ram #(.Width(1), .Depth(Sites)) u_open (
      .clock, .wr_en(o_we), .wr_addr(o_wa), .wr_data(o_wd), .rd_addr(o_ra), .rd_data(o_rd)
   );
   gpt_ram #(.Width(NW), .Depth(Nodes)) u_parent (
      .clock, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd), .rd_addr(p_ra), .rd_data(p_rd)
   );
   gpt_ram #(.Width(NW), .Depth(Nodes)) u_size (
      .clock, .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd), .rd_addr(s_ra), .rd_data(s_rd)
   );

   logic [6:0]    rr, cc;
   logic [13:0]   prod;
   logic [NW-1:0] nn1, nsq;
   logic          nb_ok;
   logic [NW-1:0] nb_node;

   always_comb begin
      rr   = {1'b0, r_ff};
      cc   = {1'b0, c_ff};
      prod = n_ff * n_ff;
      nsq  = NW'(prod);
      nn1  = NW'(prod + 14'd1);
      nb_ok   = 1'b0;
      nb_node = '0;
      case (nidx_ff)
         3'd0: begin nb_ok = (cc > 7'd1); nb_node = node_ff - NW'(1); end
         3'd1: begin nb_ok = (cc < n_ff); nb_node = node_ff + NW'(1); end
         3'd2: begin nb_ok = 1'b1; nb_node = (rr > 7'd1) ? node_ff - NW'(n_ff) : '0; end
         3'd3: begin nb_ok = 1'b1; nb_node = (rr < n_ff) ? node_ff + NW'(n_ff) : nn1; end
         default: begin nb_ok = 1'b0; nb_node = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gpt_pkg::ST_WIPE;
         side_reg_ff  <= 6'd32;
         wipe_ff      <= '0;
         total_ff     <= '0;
         wipe_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_reg_ff  <= side_reg_in;
         wipe_ff      <= wipe_in;
         total_ff     <= total_in;
         wipe_pend_ff <= wipe_pend_in;
      end
      n_ff <= n_in; op_ff <= op_in; r_ff <= r_in; c_ff <= c_in;
      node_ff <= node_in; nb_ff <= nb_in; nidx_ff <= nidx_in; cur_ff <= cur_in;
      ra_ff <= ra_in; rb_ff <= rb_in; sa_ff <= sa_in;
      bad_ff <= bad_in; sopen_ff <= sopen_in; sfull_ff <= sfull_in; perc_ff <= perc_in;
   end

   always_comb begin
      state_in = state_ff; side_reg_in = side_reg_ff; wipe_in = wipe_ff;
      total_in = total_ff; wipe_pend_in = wipe_pend_ff;
      n_in = n_ff; op_in = op_ff; r_in = r_ff; c_in = c_ff; node_in = node_ff;
      nb_in = nb_ff; nidx_in = nidx_ff; cur_in = cur_ff; ra_in = ra_ff; rb_in = rb_ff;
      sa_in = sa_ff; bad_in = bad_ff; sopen_in = sopen_ff; sfull_in = sfull_ff;
      perc_in = perc_ff;
      o_we = 1'b0; o_wa = '0; o_wd = 1'b0; o_ra = '0;
      p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = cur_ff;
      s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
      // a pending sweep holds off new transactions while still idle
      busy = (state_ff != gpt_pkg::ST_IDLE) || wipe_pend_ff;
      rsp_valid = 1'b0;
      rsp_data  = '{bad_index: bad_ff, site_open: sopen_ff, site_full: sfull_ff,
                    percolates: perc_ff, open_sites: total_ff};
      if (csr_wr_en) begin
         side_reg_in  = csr_wr_data;
         wipe_pend_in = 1'b1;
      end
      unique case (state_ff)
         gpt_pkg::ST_IDLE: begin
            if (wipe_pend_ff) begin
               wipe_in = '0; state_in = gpt_pkg::ST_WIPE; wipe_pend_in = csr_wr_en;
            end else if (start) begin
               op_in = req_data.operation; r_in = req_data.row; c_in = req_data.column;
               if (side_reg_ff == 6'd0) n_in = 7'd1;
               else if ({1'b0, side_reg_ff} > 7'(MAX_SIDE)) n_in = 7'(MAX_SIDE);
               else n_in = {1'b0, side_reg_ff};
               state_in = gpt_pkg::ST_OCHK;
               bad_in = 1'b0; sopen_in = 1'b0; sfull_in = 1'b0;
            end
         end
         gpt_pkg::ST_WIPE: begin
            p_we = 1'b1; p_wa = wipe_ff; p_wd = wipe_ff;
            s_we = 1'b1; s_wa = wipe_ff; s_wd = NW'(1);
            if (wipe_ff < NW'(Sites)) begin
               o_we = 1'b1; o_wa = SW'(wipe_ff);
            end
            total_in = '0;
            if (wipe_ff == NW'(Nodes - 1)) state_in = gpt_pkg::ST_IDLE;
            else wipe_in = wipe_ff + NW'(1);
         end
         gpt_pkg::ST_OCHK: begin
            node_in = NW'(14'(n_ff) * 14'(rr - 7'd1) + 14'(cc));
            if (op_ff == gpt_pkg::OP_CLEAR) begin
               wipe_in = '0; state_in = gpt_pkg::ST_WIPE;
               perc_in = 1'b0; op_in = gpt_pkg::OP_CLEAR;
               state_in = gpt_pkg::ST_DONE;
               total_in = '0;
            end else if (rr < 7'd1 || rr > n_ff || cc < 7'd1 || cc > n_ff) begin
               bad_in = 1'b1; state_in = gpt_pkg::ST_PT;
            end else begin
               state_in = gpt_pkg::ST_OCHK_W;
            end
         end
         gpt_pkg::ST_OCHK_W: begin
            o_ra = SW'(node_ff - NW'(1));
            state_in = (op_ff == gpt_pkg::OP_OPEN) ? gpt_pkg::ST_NRD : gpt_pkg::ST_QRD;
            nidx_in = '0;
         end
         gpt_pkg::ST_NRD: begin
            // o_rd valid: state of the addressed site
            if (o_rd) state_in = gpt_pkg::ST_QRD;
            else begin
               o_we = 1'b1; o_wa = SW'(node_ff - NW'(1)); o_wd = 1'b1;
               total_in = total_ff + CW'(1);
               state_in = gpt_pkg::ST_NSEL;
            end
         end
         gpt_pkg::ST_NSEL: begin
            if (nidx_ff == 3'd4) state_in = gpt_pkg::ST_QRD;
            else if (!nb_ok) nidx_in = nidx_ff + 3'd1;
            else begin
               nb_in = nb_node;
               if (nb_node == '0 || nb_node == nn1) state_in = gpt_pkg::ST_FA;
               else state_in = gpt_pkg::ST_NRD_W;
               cur_in = node_ff;
            end
         end
         gpt_pkg::ST_NRD_W: begin
            o_ra = SW'(nb_ff - NW'(1));
            state_in = gpt_pkg::ST_SZ_W;
            sa_in = '0;
         end
         gpt_pkg::ST_SZ_W: begin
            o_ra = SW'(nb_ff - NW'(1));
            if (sa_ff == '0) begin
               sa_in = NW'(1);
            end else if (o_rd) begin
               state_in = gpt_pkg::ST_FA;
            end else begin
               nidx_in = nidx_ff + 3'd1; state_in = gpt_pkg::ST_NSEL;
            end
         end
         // root walk of node a
         gpt_pkg::ST_FA: begin
            p_ra = cur_ff; state_in = gpt_pkg::ST_FA_W;
         end
         gpt_pkg::ST_FA_W: begin
            if (p_rd == cur_ff) begin
               ra_in = cur_ff; cur_in = nb_ff; state_in = gpt_pkg::ST_FB;
            end else begin
               cur_in = p_rd; state_in = gpt_pkg::ST_FA;
            end
         end
         gpt_pkg::ST_FB: begin
            p_ra = cur_ff; state_in = gpt_pkg::ST_FB_W;
         end
         gpt_pkg::ST_FB_W: begin
            if (p_rd == cur_ff) begin
               rb_in = cur_ff;
               if (cur_ff == ra_ff) begin
                  nidx_in = nidx_ff + 3'd1; state_in = gpt_pkg::ST_NSEL;
               end else state_in = gpt_pkg::ST_SZ;
            end else begin
               cur_in = p_rd; state_in = gpt_pkg::ST_FB;
            end
         end
         gpt_pkg::ST_SZ: begin
            s_ra = ra_ff; state_in = gpt_pkg::ST_LINK; sa_in = '0;
         end
         gpt_pkg::ST_LINK: begin
            // first pass latches size of ra, second compares against size of rb
            if (cur_ff != ra_ff) begin
               s_ra = rb_ff; sa_in = s_rd; cur_in = ra_ff;
            end else begin
               if (s_rd > sa_ff) begin
                  p_we = 1'b1; p_wa = ra_ff; p_wd = rb_ff;
                  s_we = 1'b1; s_wa = rb_ff;
               end else begin
                  p_we = 1'b1; p_wa = rb_ff; p_wd = ra_ff;
                  s_we = 1'b1; s_wa = ra_ff;
               end
               s_wd = sa_ff + s_rd;
               nidx_in = nidx_ff + 3'd1; state_in = gpt_pkg::ST_NSEL;
            end
         end
         gpt_pkg::ST_QRD: begin
            o_ra = SW'(node_ff - NW'(1)); state_in = gpt_pkg::ST_QRD_W;
         end
         gpt_pkg::ST_QRD_W: begin
            sopen_in = o_rd; cur_in = '0; state_in = gpt_pkg::ST_QF0;
         end
         gpt_pkg::ST_QF0: begin
            p_ra = cur_ff; state_in = gpt_pkg::ST_QF0_W;
         end
         gpt_pkg::ST_QF0_W: begin
            if (p_rd == cur_ff) begin
               ra_in = cur_ff; cur_in = node_ff; state_in = gpt_pkg::ST_QF1;
            end else begin
               cur_in = p_rd; state_in = gpt_pkg::ST_QF0;
            end
         end
         gpt_pkg::ST_QF1: begin
            p_ra = cur_ff; state_in = gpt_pkg::ST_QF1_W;
         end
         gpt_pkg::ST_QF1_W: begin
            if (p_rd == cur_ff) begin
               sfull_in = (cur_ff == ra_ff); state_in = gpt_pkg::ST_PT;
            end else begin
               cur_in = p_rd; state_in = gpt_pkg::ST_QF1;
            end
         end
         gpt_pkg::ST_PT: begin
            cur_in = '0; state_in = gpt_pkg::ST_PT_W; wipe_in = '0;
         end
         gpt_pkg::ST_PT_W: begin
            // wipe_ff flags second phase (bottom walk)
            p_ra = cur_ff;
            state_in = gpt_pkg::ST_PB;
         end
         gpt_pkg::ST_PB: begin
            if (p_rd == cur_ff) begin
               if (wipe_ff == '0) begin
                  ra_in = cur_ff; cur_in = nsq + NW'(1); wipe_in = NW'(1);
                  state_in = gpt_pkg::ST_PT_W;
               end else begin
                  perc_in = (cur_ff == ra_ff); state_in = gpt_pkg::ST_PB_W;
               end
            end else begin
               cur_in = p_rd; state_in = gpt_pkg::ST_PT_W;
            end
         end
         gpt_pkg::ST_PB_W: begin
            wipe_in = '0; state_in = gpt_pkg::ST_DONE;
         end
         gpt_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (op_ff == gpt_pkg::OP_CLEAR) begin
               wipe_in = '0; state_in = gpt_pkg::ST_WIPE;
            end else state_in = gpt_pkg::ST_IDLE;
         end
         default: state_in = gpt_pkg::ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response outside transaction");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && op_ff != gpt_pkg::OP_CLEAR) |=> !busy || wipe_pend_ff)
      else $error("done did not return to idle");
   a_bad_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_index) |-> !rsp_data.site_open && !rsp_data.site_full)
      else $error("bad index with site flags");
`endif

endmodule

// ===== hw/rtl/gpt_ram.sv =====
`timescale 1ns / 1ps
module gpt_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

   localparam int unsigned NODE_TOTAL = 1026;
   localparam int unsigned STALL_LIMIT = 20000;

   class percolation_scoreboard;
      bit                  site_is_open[1024];
      int unsigned         parent[NODE_TOTAL];
      int unsigned         tree_weight[NODE_TOTAL];
      int unsigned         open_total;
      logic [5:0]          side_reg;
      gpt_pkg::rsp_type    expected_rsp[$];
      int unsigned         mismatches;

      function void wipe();
         for (int i = 0; i < NODE_TOTAL; i++) begin
            parent[i] = i;
            tree_weight[i] = 1;
         end
         for (int i = 0; i < 1024; i++) site_is_open[i] = 1'b0;
         open_total = 0;
      endfunction

      function void reset_state();
         side_reg = 6'd32;
         mismatches = 0;
         wipe();
      endfunction

      function void write_side(logic [5:0] value);
         side_reg = value;
         wipe();
      endfunction

      function int unsigned side_now();
         if (side_reg < 1) return 1;
         if (side_reg > 32) return 32;
         return 32'(side_reg);
      endfunction

      function int unsigned root_of(int unsigned x);
         while (parent[x] != x) x = parent[x];
         return x;
      endfunction

      function void join_nodes(int unsigned a, int unsigned b);
         int unsigned ra;
         int unsigned rb;
         int unsigned t;
         ra = root_of(a);
         rb = root_of(b);
         if (ra == rb) return;
         if (tree_weight[ra] < tree_weight[rb]) begin
            t = ra;
            ra = rb;
            rb = t;
         end
         parent[rb] = ra;
         tree_weight[ra] = tree_weight[ra] + tree_weight[rb];
      endfunction

      function bit node_open(int unsigned node);
         if (node < 1 || node > 1024) return 1'b0;
         return site_is_open[node - 1];
      endfunction

      function void open_node(int unsigned r, int unsigned c, int unsigned n);
         int unsigned node;
         node = 1 + n * (r - 1) + (c - 1);
         if (node_open(node)) return;
         site_is_open[node - 1] = 1'b1;
         open_total++;
         if (c > 1 && node_open(node - 1)) join_nodes(node, node - 1);
         if (c < n && node_open(node + 1)) join_nodes(node, node + 1);
         if (r > 1) begin
            if (node_open(node - n)) join_nodes(node, node - n);
         end else begin
            join_nodes(node, 0);
         end
         if (r < n) begin
            if (node_open(node + n)) join_nodes(node, node + n);
         end else begin
            join_nodes(node, n * n + 1);
         end
      endfunction

      function void note_request(gpt_pkg::req_type req);
         gpt_pkg::rsp_type rsp;
         int unsigned n;
         int unsigned r;
         int unsigned c;
         int unsigned node;
         n = side_now();
         r = 32'(req.row);
         c = 32'(req.column);
         rsp = '0;
         if (req.operation == gpt_pkg::OP_CLEAR) begin
            wipe();
         end else if (r < 1 || r > n || c < 1 || c > n) begin
            rsp.bad_index = 1'b1;
         end else begin
            node = 1 + n * (r - 1) + (c - 1);
            if (req.operation == gpt_pkg::OP_OPEN) open_node(r, c, n);
            rsp.site_open = node_open(node);
            rsp.site_full = (root_of(0) == root_of(node));
         end
         rsp.percolates = (root_of(0) == root_of(n * n + 1));
         rsp.open_sites = open_total[10:0];
         expected_rsp.push_back(rsp);
      endfunction

      function bit check_response(gpt_pkg::rsp_type got);
         gpt_pkg::rsp_type want;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return 1'b0;
         end
         want = expected_rsp.pop_front();
         if (got.bad_index !== want.bad_index || got.site_open !== want.site_open ||
             got.site_full !== want.site_full || got.percolates !== want.percolates ||
             got.open_sites !== want.open_sites) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            return 1'b0;
         end
         return 1'b1;
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   gpt_pkg::req_type req_data;
   logic             rsp_valid;
   gpt_pkg::rsp_type rsp_data;
   logic             csr_wr_en;
   logic [5:0]       csr_wr_data;

   percolation_scoreboard grid_model;
   int unsigned idle_pct;
   int unsigned quiet_cycles;

   grid_percolation_tracker_core dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // results are checked before a new transaction is noted at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) void'(grid_model.check_response(rsp_data));
         if (start && !busy) grid_model.note_request(req_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(logic [1:0] op, logic [5:0] r, logic [5:0] c);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_data <= '{operation: op, row: r, column: c};
      do @(posedge clock); while (busy);
   endtask

   task automatic set_side(logic [5:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (grid_model.expected_rsp.size() != 0 || busy) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      grid_model.write_side(value);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_item(int unsigned n);
      int unsigned pick;
      logic [1:0]  op;
      pick = $urandom_range(99);
      if (pick < 55) begin
         send_item(gpt_pkg::OP_OPEN, 6'($urandom_range(1, n)), 6'($urandom_range(1, n)));
      end else if (pick < 80) begin
         send_item(gpt_pkg::OP_QUERY, 6'($urandom_range(1, n)), 6'($urandom_range(1, n)));
      end else if (pick < 86) begin
         send_item(2'd3, 6'($urandom_range(1, n)), 6'($urandom_range(1, n)));
      end else if (pick < 98) begin
         op = 2'($urandom_range(3));
         if (op == gpt_pkg::OP_CLEAR) op = gpt_pkg::OP_OPEN;
         send_item(op, 6'($urandom_range(63)), 6'($urandom_range(63)));
      end else begin
         send_item(gpt_pkg::OP_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)));
      end
   endtask

   task automatic run_phase(logic [5:0] side_value, int unsigned items, int unsigned pct);
      int unsigned n;
      set_side(side_value);
      idle_pct = pct;
      n = grid_model.side_now();
      repeat (items) random_item(n);
   endtask

   initial begin
      grid_model = new();
      grid_model.reset_state();
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      quiet_cycles <= 0;
      idle_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, bad addresses, reopen, unknown op, clear
      send_item(gpt_pkg::OP_OPEN, 6'd1, 6'd1);
      send_item(gpt_pkg::OP_OPEN, 6'd1, 6'd1);
      send_item(gpt_pkg::OP_OPEN, 6'd32, 6'd32);
      send_item(gpt_pkg::OP_QUERY, 6'd32, 6'd32);
      send_item(gpt_pkg::OP_OPEN, 6'd0, 6'd5);
      send_item(gpt_pkg::OP_QUERY, 6'd5, 6'd0);
      send_item(gpt_pkg::OP_OPEN, 6'd33, 6'd1);
      send_item(gpt_pkg::OP_QUERY, 6'd63, 6'd63);
      send_item(2'd3, 6'd1, 6'd1);
      send_item(gpt_pkg::OP_CLEAR, 6'd63, 6'd63);
      send_item(gpt_pkg::OP_QUERY, 6'd1, 6'd1);
      set_side(6'd1);
      send_item(gpt_pkg::OP_QUERY, 6'd1, 6'd1);
      send_item(gpt_pkg::OP_OPEN, 6'd1, 6'd1);
      send_item(gpt_pkg::OP_QUERY, 6'd1, 6'd2);
      set_side(6'd2);
      // bottom row opened first so the backwash path shows up
      send_item(gpt_pkg::OP_OPEN, 6'd2, 6'd1);
      send_item(gpt_pkg::OP_OPEN, 6'd2, 6'd2);
      send_item(gpt_pkg::OP_OPEN, 6'd1, 6'd2);
      send_item(gpt_pkg::OP_QUERY, 6'd2, 6'd1);
      send_item(gpt_pkg::OP_QUERY, 6'd1, 6'd1);

      run_phase(6'd0, 40, 0);
      run_phase(6'd3, 120, 79);
      run_phase(6'd5, 200, 0);
      run_phase(6'd8, 200, 12);
      run_phase(6'd63, 150, 0);
      run_phase(6'd32, 80, 79);
      run_phase(6'd4, 150, 12);
      run_phase(6'($urandom_range(1, 12)), 80, 0);

      start <= 1'b0;
      while (grid_model.expected_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (grid_model.mismatches == 0 && grid_model.expected_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/gpt_pkg.sv
hw/rtl/gpt_ram.sv
hw/rtl/grid_percolation_tracker_core.sv
tb/tb_top.sv
